@@ rtl/core/pairwise_repulsion_force_accumulator_defines.svh @@
// ---------------------------------------------------------------------------
// Pairwise repulsion force accumulator - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_REPULSION_FORCE_ACCUMULATOR_DEFINES_SVH
`define PAIRWISE_REPULSION_FORCE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication
`define PRFA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/prfa_pkg.sv @@
// ---------------------------------------------------------------------------
// prfa_pkg
// Widths, codes and shared types of the pairwise repulsion force accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package prfa_pkg;

    // Field widths
    localparam int ID_W    = 16;
    localparam int POS_W   = 24;
    localparam int DIF_W   = POS_W + 1;
    localparam int MAG_W   = POS_W;
    localparam int K_W     = 16;
    localparam int R_W     = 23;
    localparam int CFG_W   = 23;
    localparam int OUT_W   = 32;
    localparam int SUM_W   = 40;

    // Datapath widths
    localparam int PROD_W  = 2 * MAG_W;
    localparam int RAD_W   = PROD_W + 1;
    localparam int ROOT_W  = 25;
    localparam int SMAG_W  = R_W;
    localparam int KS_W    = K_W + SMAG_W;
    localparam int KS_LO_W = MAG_W;
    localparam int QUO_W   = 24;
    localparam int DEN_W   = R_W + K_W;
    localparam int NUM_W   = DEN_W + QUO_W;
    localparam int TERM_W  = QUO_W + 1;

    // Operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_NEIGH  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_REPEL   = 2'd0;
    localparam logic [1:0] CFG_ATTRACT = 2'd1;
    localparam logic [1:0] CFG_RADIUS  = 2'd2;

    // Register reset values
    localparam logic [K_W-1:0] REPEL_RST   = 16'd6554;
    localparam logic [K_W-1:0] ATTRACT_RST = 16'd0;
    localparam logic [R_W-1:0] RADIUS_RST  = 23'd8192;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pairwise_repulsion_force_accumulator.sv @@
// Start, finish and unused op codes leave the sequencer idle, so the input stays ready.
// A neighbour item holds the input while it is worked on: the offsets are squared
// in the shared 24x24 multiplier, the square root gives the distance, and in range
// each axis then passes the multiplier and divider; own-id items are taken at once.
// The finish result waits in an output register; only another finish is held back.
// Reset (async, active low) clears the agent, the sums and loads register defaults.
// ---------------------------------------------------------------------------
// pairwise_repulsion_force_accumulator
// Linear spring force from a run of neighbours on one agent, fixed point,
// with a shared multiplier, an iterative square root and an iterative divider.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pairwise_repulsion_force_accumulator_defines.svh"

module pairwise_repulsion_force_accumulator
    import prfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [ID_W-1:0]         ident,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    // Output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] force_x,
    output logic signed [OUT_W-1:0] force_y,
    // Configuration channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_SQRT,
        ST_SEP,
        ST_KS,
        ST_KS_HOLD,
        ST_LO,
        ST_HI,
        ST_NUM,
        ST_DIV,
        ST_ACC
    } state_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Saturate a sum to the output width
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-OUT_W:0] top;
        top = v[SUM_W-1:OUT_W-1];
        if (top == {(SUM_W-OUT_W+1){v[SUM_W-1]}})
            return v[OUT_W-1:0];
        else
            return v[SUM_W-1] ? OUT_MIN : OUT_MAX;
    endfunction

    // Saturating add of one signed term to a sum
    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [TERM_W-1:0] b);
        logic signed [SUM_W:0] t;
        t = {a[SUM_W-1], a} + {{(SUM_W+1-TERM_W){b[TERM_W-1]}}, b};
        if (t[SUM_W] != t[SUM_W-1])
            return t[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            return t[SUM_W-1:0];
    endfunction

    // Control and state registers
    state_t                   state_reg, state_next;
    logic                     axis_reg, axis_next;
    logic [K_W-1:0]           repel_reg, repel_next;
    logic [K_W-1:0]           attract_reg, attract_next;
    logic [R_W-1:0]           radius_reg, radius_next;
    logic [ID_W-1:0]          own_ident_reg, own_ident_next;
    logic signed [POS_W-1:0]  own_x_reg, own_x_next;
    logic signed [POS_W-1:0]  own_y_reg, own_y_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  force_x_reg, force_x_next;
    logic signed [OUT_W-1:0]  force_y_reg, force_y_next;

    // Datapath registers
    logic [MAG_W-1:0]         dmag_x_reg, dmag_y_reg;
    logic                     dneg_x_reg, dneg_y_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        sqx_reg;
    logic [SMAG_W-1:0]        smag_reg;
    logic [K_W-1:0]           k_reg;
    logic [KS_W-1:0]          ks_reg;
    logic [PROD_W-1:0]        lo_reg;

    // Combinational
    logic                     in_fire;
    logic [DIF_W-1:0]         dx_w, dy_w, dx_neg, dy_neg;
    logic [MAG_W-1:0]         dmag_x_in, dmag_y_in, dmag_axis;
    logic [MAG_W-1:0]         mul_a, mul_b;
    logic [ROOT_W-1:0]        root;
    logic [ROOT_W-1:0]        sep_up, sep_dn;
    logic                     near, attract;
    logic [QUO_W-1:0]         quot;
    logic signed [TERM_W-1:0] term;
    unit_stat_t               sq_stat, dv_stat;
    logic                     sq_start, dv_start;
    logic [RAD_W-1:0]         radicand;
    logic [NUM_W-1:0]         numer;

    // Handshakes
    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE)
                       && !(op == OP_FINISH && out_valid_reg && !out_ready);
    assign cfg_ready = 1'b1;

    // Offsets to the neighbour and their magnitudes
    assign dx_w      = {own_x_reg[POS_W-1], own_x_reg} - {pos_x[POS_W-1], pos_x};
    assign dy_w      = {own_y_reg[POS_W-1], own_y_reg} - {pos_y[POS_W-1], pos_y};
    assign dx_neg    = DIF_W'(0) - dx_w;
    assign dy_neg    = DIF_W'(0) - dy_w;
    assign dmag_x_in = dx_w[DIF_W-1] ? dx_neg[MAG_W-1:0] : dx_w[MAG_W-1:0];
    assign dmag_y_in = dy_w[DIF_W-1] ? dy_neg[MAG_W-1:0] : dy_w[MAG_W-1:0];
    assign dmag_axis = axis_reg ? dmag_y_reg : dmag_x_reg;

    // Separation against the radius
    assign sep_up  = root - ROOT_W'(radius_reg);
    assign sep_dn  = ROOT_W'(radius_reg) - root;
    assign near    = (root < {1'b0, radius_reg, 1'b0});
    assign attract = (root > ROOT_W'(radius_reg));

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_X:
            begin
                mul_a = dmag_x_reg;
                mul_b = dmag_x_reg;
            end
            ST_SQ_Y:
            begin
                mul_a = dmag_y_reg;
                mul_b = dmag_y_reg;
            end
            ST_KS:
            begin
                mul_a = MAG_W'(smag_reg);
                mul_b = MAG_W'(k_reg);
            end
            ST_LO:
            begin
                mul_a = ks_reg[KS_LO_W-1:0];
                mul_b = dmag_axis;
            end
            ST_HI:
            begin
                mul_a = MAG_W'(ks_reg[KS_W-1:KS_LO_W]);
                mul_b = dmag_axis;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Unit operands
    assign sq_start = (state_reg == ST_SQ_SUM);
    assign radicand = {1'b0, sqx_reg} + {1'b0, prod_reg};
    assign dv_start = (state_reg == ST_NUM);
    assign numer    = NUM_W'(lo_reg) + {prod_reg[NUM_W-KS_LO_W-1:0], KS_LO_W'(0)};

    // Term sign follows the offset sign (zero separation gives a zero quotient)
    assign term = (axis_reg ? dneg_y_reg : dneg_x_reg)
                  ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    prfa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .stat     (sq_stat),
        .root     (root)
    );

    prfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .numer (numer),
        .denom ({radius_reg, K_W'(0)}),
        .stat  (dv_stat),
        .quot  (quot)
    );

    // Sequencer and next state
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        repel_next     = repel_reg;
        attract_next   = attract_reg;
        radius_next    = radius_reg;
        own_ident_next = own_ident_reg;
        own_x_next     = own_x_reg;
        own_y_next     = own_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        out_valid_next = out_valid_reg;
        force_x_next   = force_x_reg;
        force_y_next   = force_y_reg;

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REPEL:   repel_next   = cfg_data[K_W-1:0];
                CFG_ATTRACT: attract_next = cfg_data[K_W-1:0];
                CFG_RADIUS:  radius_next  = cfg_data[R_W-1:0];
                default:     ;
            endcase
        end

        // Output transfer
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        OP_START:
                        begin
                            own_ident_next = ident;
                            own_x_next     = pos_x;
                            own_y_next     = pos_y;
                            sum_x_next     = '0;
                            sum_y_next     = '0;
                        end
                        OP_NEIGH:
                        begin
                            if (ident != own_ident_reg)
                                state_next = ST_SQ_X;
                        end
                        OP_FINISH:
                        begin
                            out_valid_next = 1'b1;
                            force_x_next   = sat_out(sum_x_reg);
                            force_y_next   = sat_out(sum_y_reg);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SQ_SUM;
            ST_SQ_SUM: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sq_stat.done)
                    state_next = ST_SEP;
            end
            ST_SEP:    state_next = near ? ST_KS : ST_IDLE;
            ST_KS:     state_next = ST_KS_HOLD;
            ST_KS_HOLD:
            begin
                axis_next  = 1'b0;
                state_next = ST_LO;
            end
            ST_LO:     state_next = ST_HI;
            ST_HI:     state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (dv_stat.done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (axis_reg)
                begin
                    sum_y_next = sat_add(sum_y_reg, term);
                    state_next = ST_IDLE;
                end
                else
                begin
                    sum_x_next = sat_add(sum_x_reg, term);
                    axis_next  = 1'b1;
                    state_next = ST_LO;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            repel_reg     <= REPEL_RST;
            attract_reg   <= ATTRACT_RST;
            radius_reg    <= RADIUS_RST;
            own_ident_reg <= '0;
            own_x_reg     <= '0;
            own_y_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            force_x_reg   <= '0;
            force_y_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            repel_reg     <= repel_next;
            attract_reg   <= attract_next;
            radius_reg    <= radius_next;
            own_ident_reg <= own_ident_next;
            own_x_reg     <= own_x_next;
            own_y_reg     <= own_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            out_valid_reg <= out_valid_next;
            force_x_reg   <= force_x_next;
            force_y_reg   <= force_y_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_fire)
        begin
            dmag_x_reg <= dmag_x_in;
            dmag_y_reg <= dmag_y_in;
            dneg_x_reg <= dx_w[DIF_W-1];
            dneg_y_reg <= dy_w[DIF_W-1];
        end
        if (state_reg == ST_SQ_Y)
            sqx_reg <= prod_reg;
        if (state_reg == ST_SEP)
        begin
            smag_reg <= attract ? sep_up[SMAG_W-1:0] : sep_dn[SMAG_W-1:0];
            k_reg    <= attract ? attract_reg : repel_reg;
        end
        if (state_reg == ST_KS_HOLD)
            ks_reg <= prod_reg[KS_W-1:0];
        if (state_reg == ST_HI)
            lo_reg <= prod_reg;
    end

    assign out_valid = out_valid_reg;
    assign force_x   = force_x_reg;
    assign force_y   = force_y_reg;

    // Assertions
    `PRFA_ASSERT_IMPL(a_sqrt_busy_in_wait, sq_stat.busy, state_reg == ST_SQRT,
        "square root unit busy outside its wait state")
    `PRFA_ASSERT_IMPL(a_div_busy_in_wait, dv_stat.busy, state_reg == ST_DIV,
        "divider busy outside its wait state")
    `PRFA_ASSERT_NEXT(a_finish_loads_out, in_fire && op == OP_FINISH, out_valid_reg,
        "finish transfer did not load the output register")
    `PRFA_ASSERT_NEXT(a_sums_hold_idle, state_reg == ST_IDLE && !in_fire,
        $stable(sum_x_reg) && $stable(sum_y_reg), "force sums changed while idle")

endmodule

`default_nettype wire

@@ rtl/core/prfa_sqrt.sv @@
// ---------------------------------------------------------------------------
// prfa_sqrt
// Iterative integer square root, one root bit per cycle (restoring form).
// ---------------------------------------------------------------------------
`default_nettype none

module prfa_sqrt
    import prfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output unit_stat_t        stat,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;

    // One root bit per step: bring down two radicand bits, try 4*root+1
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = (2*ROOT_W)'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = diff[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

@@ rtl/core/prfa_div.sv @@
// ---------------------------------------------------------------------------
// prfa_div
// Iterative restoring divider, one quotient bit per cycle. The caller
// guarantees numer < denom * 2^QUO_W, so the quotient fits QUO_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module prfa_div
    import prfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output unit_stat_t       stat,
    output logic [QUO_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Shift one numerator bit into the remainder, subtract if it fits;
    // quotient bits replace the numerator bits in the same register
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[QUO_W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer[NUM_W-1 -: DEN_W];
            quo_next  = numer[QUO_W-1:0];
            den_next  = denom;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - pairwise repulsion force accumulator testbench
// Drives start, neighbor and finish transfers with random idling on both
// channels, predicts the saturated force sums and checks every result.
// ---------------------------------------------------------------------------
module tb_top;
    import prfa_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE  = 2'd3;

    localparam int CLK_HALF      = 1;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 120;       // outlasts a neighbor hold
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;

    localparam longint SUM_HI = 40'sh7F_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint OUT_HI = 32'sh7FFF_FFFF;
    localparam longint OUT_LO = -OUT_HI - 1;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [R_W-1:0]          RAD_MAX = {R_W{1'b1}};
    localparam logic [K_W-1:0]          K_MAX   = {K_W{1'b1}};

    // Saturation run: neighbor offset that keeps d just under twice the radius
    localparam longint          SAT_SPAN = 11_800_000;
    localparam logic [ID_W-1:0] SAT_ID   = 16'h1234;

    typedef struct packed {
        logic signed [OUT_W-1:0] fx;
        logic signed [OUT_W-1:0] fy;
    } force_pair_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              op;
    logic [ID_W-1:0]         ident;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    // Predicted block state
    logic [K_W-1:0]          repel_k;
    logic [K_W-1:0]          attract_k;
    logic [R_W-1:0]          radius;
    logic [ID_W-1:0]         agent_ident;
    logic signed [POS_W-1:0] agent_x;
    logic signed [POS_W-1:0] agent_y;
    longint                  sum_fx;
    longint                  sum_fy;

    force_pair_t expected_forces[$];
    force_pair_t want_force;
    int          mismatch_count;
    int          items_sent;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    pairwise_repulsion_force_accumulator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .ident     (ident),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .force_x   (force_x),
        .force_y   (force_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ---------------------------------------------------------------------
    // Force predictor
    // ---------------------------------------------------------------------
    function automatic longint unsigned abs_mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Floor square root, one result bit per pass
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // k*s*axis / (R * 2^16), truncated toward zero
    function automatic longint spring_term(longint unsigned k_mag, bit k_neg, longint sep,
                                           longint axis, longint unsigned rad);
        longint unsigned quo;
        bit              neg;
        if (rad == 0)
            return 0;
        quo = (k_mag * abs_mag(sep) * abs_mag(axis)) / (rad << 16);
        neg = k_neg ^ (sep < 0) ^ (axis < 0);
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic void accumulate_force(logic [1:0] item_op, logic [ID_W-1:0] item_id,
                                             logic signed [POS_W-1:0] px,
                                             logic signed [POS_W-1:0] py);
        longint          dx;
        longint          dy;
        longint          span;
        longint          sep;
        longint          rad;
        longint unsigned k_mag;
        bit              k_neg;
        force_pair_t     res;
        case (item_op)
            OP_START:
            begin
                agent_ident = item_id;
                agent_x     = px;
                agent_y     = py;
                sum_fx      = 0;
                sum_fy      = 0;
            end
            OP_NEIGH:
            begin
                // a neighbor carrying the agent's own id is skipped
                if (item_id != agent_ident)
                begin
                    dx   = longint'(agent_x) - longint'(px);
                    dy   = longint'(agent_y) - longint'(py);
                    span = longint'(int_sqrt(abs_mag(dx) * abs_mag(dx)
                                             + abs_mag(dy) * abs_mag(dy)));
                    rad  = longint'(radius);
                    sep  = span - rad;
                    if (sep < rad)
                    begin
                        if (sep > 0)
                        begin
                            k_mag = attract_k;
                            k_neg = 1'b0;
                        end
                        else
                        begin
                            k_mag = repel_k;
                            k_neg = 1'b1;
                        end
                        sum_fx = clamp(sum_fx + spring_term(k_mag, k_neg, sep, dx, radius),
                                       SUM_LO, SUM_HI);
                        sum_fy = clamp(sum_fy + spring_term(k_mag, k_neg, sep, dy, radius),
                                       SUM_LO, SUM_HI);
                    end
                end
            end
            OP_FINISH:
            begin
                res.fx = OUT_W'(clamp(sum_fx, OUT_LO, OUT_HI));
                res.fy = OUT_W'(clamp(sum_fy, OUT_LO, OUT_HI));
                expected_forces.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_forces.size() == 0)
                note_mismatch($sformatf("result with none expected: force_x %0d force_y %0d",
                                        force_x, force_y));
            else
            begin
                want_force = expected_forces.pop_front();
                if (force_x !== want_force.fx)
                    note_mismatch($sformatf("force_x expected %0d got %0d",
                                            want_force.fx, force_x));
                if (force_y !== want_force.fy)
                    note_mismatch($sformatf("force_y expected %0d got %0d",
                                            want_force.fy, force_y));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Channel tasks; each is entered and left at a falling edge
    // ---------------------------------------------------------------------
    task automatic send_item(logic [1:0] item_op, logic [ID_W-1:0] item_id,
                             logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= item_op;
        ident    <= item_id;
        pos_x    <= px;
        pos_y    <= py;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_force(item_op, item_id, px, py);
        if (item_op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_REPEL:   repel_k   = data[K_W-1:0];
            CFG_ATTRACT: attract_k = data[K_W-1:0];
            CFG_RADIUS:  radius    = data[R_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_forces.size() != 0)
            @(negedge clk);
    endtask

    // Wait out results and any neighbor still being worked on
    task automatic settle();
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Coordinate within reach of a center, kept inside the field range
    function automatic logic signed [POS_W-1:0] near_coord(logic signed [POS_W-1:0] center,
                                                          longint reach);
        longint off;
        longint cand;
        off  = longint'($urandom_range(32'(2 * reach))) - reach;
        cand = longint'(center) - off;
        if (cand > longint'(POS_MAX) || cand < longint'(POS_MIN))
            cand = longint'(center) + off;
        return POS_W'(clamp(cand, longint'(POS_MIN), longint'(POS_MAX)));
    endfunction

    task automatic randomize_config();
        logic [R_W-1:0] rad;
        settle();
        case ($urandom_range(7))
            0:       write_reg(CFG_REPEL, CFG_W'(0));
            1:       write_reg(CFG_REPEL, CFG_W'(K_MAX));
            default: write_reg(CFG_REPEL, CFG_W'($urandom));
        endcase
        case ($urandom_range(7))
            0:       write_reg(CFG_ATTRACT, CFG_W'(0));
            default: write_reg(CFG_ATTRACT, CFG_W'($urandom));
        endcase
        case ($urandom_range(5))
            0:       rad = R_W'($urandom_range(1, 15));
            1:       rad = R_W'($urandom_range(16, 4095));
            2:       rad = R_W'($urandom_range(4096, 65535));
            3:       rad = R_W'($urandom_range(65536, 32'(RAD_MAX)));
            4:       rad = RAD_MAX;
            default: rad = R_W'($urandom);
        endcase
        if (rad == 0)
            rad = 1;
        write_reg(CFG_RADIUS, CFG_W'(rad));
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Neighbors against the agent left by reset, unused op, repeated finish
    task automatic test_reset_state();
        send_item(OP_NEIGH, 16'h0000, 24'sd4096, 24'sd0);
        send_item(OP_NEIGH, 16'h0001, 24'sd4096, 24'sd0);
        send_item(OP_NEIGH, 16'h0002, -24'sd3000, 24'sd5000);
        send_item(OP_UNUSED, 16'hFFFF, POS_MAX, POS_MIN);
        send_item(OP_FINISH, 16'h0000, 24'sd0, 24'sd0);
        send_item(OP_FINISH, 16'hFFFF, POS_MIN, POS_MAX);
    endtask

    // Field and register extremes, zero separation, zero radius
    task automatic test_extremes();
        settle();
        write_reg(CFG_REPEL, CFG_W'(K_MAX));
        write_reg(CFG_ATTRACT, CFG_W'(K_MAX));
        write_reg(CFG_RADIUS, CFG_W'(RAD_MAX));
        send_item(OP_START, 16'hFFFF, POS_MAX, POS_MIN);
        send_item(OP_NEIGH, 16'h0000, POS_MIN, POS_MAX);          // out of range
        send_item(OP_NEIGH, 16'h8000, POS_MAX, POS_MIN);          // coincident
        send_item(OP_NEIGH, 16'h0001, 24'sd0, POS_MIN);           // d equals radius
        send_item(OP_NEIGH, 16'h7FFF, POS_MIN + 24'sd3, POS_MIN); // strongest pull
        send_item(OP_NEIGH, 16'hFFFF, 24'sd0, 24'sd0);            // own id
        send_item(OP_NEIGH, 16'h00FF, POS_MAX, 24'sd0);           // just past radius
        send_item(OP_FINISH, 16'h0000, 24'sd0, 24'sd0);

        // smallest radius
        settle();
        write_reg(CFG_RADIUS, CFG_W'(1));
        send_item(OP_START, 16'h5555, 24'sd0, 24'sd0);
        send_item(OP_NEIGH, 16'hAAAA, 24'sd0, 24'sd0);
        send_item(OP_NEIGH, 16'hAAAA, 24'sd1, 24'sd0);
        send_item(OP_NEIGH, 16'hAAAA, 24'sd1, 24'sd1);
        send_item(OP_NEIGH, 16'hAAAA, 24'sd2, 24'sd0);
        send_item(OP_FINISH, 16'h0000, 24'sd0, 24'sd0);

        // zero radius adds nothing
        settle();
        write_reg(CFG_RADIUS, CFG_W'(0));
        send_item(OP_NEIGH, 16'h1111, 24'sd0, 24'sd0);
        send_item(OP_NEIGH, 16'h2222, 24'sd100, -24'sd7);
        send_item(OP_FINISH, 16'h0000, 24'sd0, 24'sd0);

        // zero stiffness, and a write to the unmapped index
        settle();
        write_reg(CFG_REPEL, CFG_W'(0));
        write_reg(CFG_RADIUS, CFG_W'(RADIUS_RST));
        write_reg(CFG_NONE, {CFG_W{1'b1}});
        send_item(OP_NEIGH, 16'h3333, 24'sd4096, -24'sd4096);
        send_item(OP_FINISH, 16'h0000, 24'sd0, 24'sd0);
    endtask

    // Agent runs with random content, plus broken sequences and noise
    task automatic test_random_runs(int target);
        int                      run_idx;
        int                      n_neigh;
        logic [ID_W-1:0]         own_id;
        logic [ID_W-1:0]         nid;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        longint                  reach;
        run_idx = 0;
        while (items_sent < target)
        begin
            if (run_idx % 16 == 0)
                randomize_config();
            run_idx++;
            if ($urandom_range(9) < 8)
            begin
                own_id = ID_W'($urandom);
                cx     = POS_W'($urandom);
                cy     = POS_W'($urandom);
                // now and then the start is left out and the last agent carries on
                if ($urandom_range(5) != 0)
                    send_item(OP_START, own_id, cx, cy);
                reach   = 2 * longint'(radius) + 2;
                n_neigh = $urandom_range(1, 10);
                repeat (n_neigh)
                begin
                    nid = ID_W'($urandom);
                    case ($urandom_range(9))
                        0:
                        begin
                            nid = own_id;
                            nx  = near_coord(cx, reach);
                            ny  = near_coord(cy, reach);
                        end
                        1:
                        begin
                            nx = POS_W'($urandom);
                            ny = POS_W'($urandom);
                        end
                        default:
                        begin
                            nx = near_coord(cx, reach);
                            ny = near_coord(cy, reach);
                        end
                    endcase
                    send_item(OP_NEIGH, nid, nx, ny);
                end
                send_item(OP_FINISH, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom));
                if ($urandom_range(7) == 0)
                    send_item(OP_FINISH, ID_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom));
                if ($urandom_range(11) == 0)
                    drain_results();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(3)), ID_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom));
            end
        end
    endtask

    // Long runs of strong pulls drive both output sums into saturation
    task automatic test_force_saturation();
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        longint                  jx;
        longint                  jy;
        logic [ID_W-1:0]         nid;
        settle();
        write_reg(CFG_REPEL, CFG_W'(K_MAX));
        write_reg(CFG_ATTRACT, CFG_W'(K_MAX));
        write_reg(CFG_RADIUS, CFG_W'(RAD_MAX));
        for (int side = 0; side < 2; side++)
        begin
            ax = side ? POS_MIN : POS_MAX;
            ay = side ? POS_MAX : POS_MIN;
            send_item(OP_START, SAT_ID, ax, ay);
            for (int n = 0; n < 200; n++)
            begin
                jx  = SAT_SPAN - longint'($urandom_range(2000));
                jy  = SAT_SPAN - longint'($urandom_range(2000));
                nid = ID_W'($urandom);
                if (nid == SAT_ID)
                    nid = nid ^ 16'h0001;
                send_item(OP_NEIGH, nid, POS_W'(side ? ax + jx : ax - jx),
                          POS_W'(side ? ay - jy : ay + jy));
                if (n == 100)
                    send_item(OP_FINISH, ID_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom));
            end
            send_item(OP_FINISH, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            send_item(OP_FINISH, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_START;
        ident          = '0;
        pos_x          = '0;
        pos_y          = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_REPEL;
        cfg_data       = '0;
        repel_k        = REPEL_RST;
        attract_k      = ATTRACT_RST;
        radius         = RADIUS_RST;
        agent_ident    = '0;
        agent_x        = '0;
        agent_y        = '0;
        sum_fx         = 0;
        sum_fy         = 0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 82;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_extremes();
        test_random_runs(450);

        send_idle_pct = 82;
        recv_idle_pct = 19;
        test_random_runs(900);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_force_saturation();
        test_random_runs(1600);

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
